[sv/prle_pkg.sv]
// shared constants and types for the pixel row run-length encoder
package prle_pkg;

    localparam int VALUE_W            = 16;
    localparam int COUNT_W            = 13;
    localparam int KIND_W             = 2;
    localparam int THR_W              = 4;
    localparam int PIXEL_BITS_DEF     = 16;
    localparam int MAX_RUN_LENGTH_DEF = 4096;
    localparam int FIFO_DEPTH_DEF     = 4;

    typedef logic [KIND_W-1:0]  t_kind;
    typedef logic [VALUE_W-1:0] t_value;
    typedef logic [COUNT_W-1:0] t_count;
    typedef logic [THR_W-1:0]   t_thr;

    localparam t_kind KIND_LITERAL = 2'd0;
    localparam t_kind KIND_RUN     = 2'd1;
    localparam t_kind KIND_ROW_END = 2'd2;
    localparam t_kind KIND_UNUSED  = 2'd3;

    localparam t_thr THR_RESET = 4'd3;
    localparam t_thr THR_CAP   = 4'd8;

endpackage

[sv/prle_if.sv]
// pixel input and token output channels
interface prle_pix_if;
    import prle_pkg::*;

    logic   valid;
    logic   ready;
    t_value pixel_value;
    logic   row_end;

    modport source (output valid, output pixel_value, output row_end, input ready);
    modport sink   (input valid, input pixel_value, input row_end, output ready);
endinterface

interface prle_tok_if;
    import prle_pkg::*;

    logic   valid;
    logic   ready;
    t_kind  token_kind;
    t_value token_value;
    t_count run_count;
    logic   last_of_burst;

    modport source (output valid, output token_kind, output token_value, output run_count,
                    output last_of_burst, input ready);
    modport sink   (input valid, input token_kind, input token_value, input run_count,
                    input last_of_burst, output ready);
endinterface

[sv/prle_front.sv]
// front end: run tracking, threshold register and flush command build
module prle_front #(
    parameter int  PIXEL_BITS     = prle_pkg::PIXEL_BITS_DEF,
    parameter int  MAX_RUN_LENGTH = prle_pkg::MAX_RUN_LENGTH_DEF,
    parameter int  LEN_W          = 13,
    parameter type t_cmd          = logic
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    prle_pix_if.sink             i_pix,
    input  logic                 i_cfg_we,
    input  prle_pkg::t_thr       i_cfg_data,
    input  logic                 i_full,
    output logic                 o_push,
    output t_cmd                 o_cmd
);
    import prle_pkg::*;

    logic [PIXEL_BITS-1:0] r_cur_val, n_cur_val;
    logic [LEN_W-1:0]      r_cur_len, n_cur_len;
    t_thr                  r_thr;

    logic                  w_accept;
    logic [PIXEL_BITS-1:0] w_pix;
    logic [LEN_W-1:0]      w_thr;
    logic                  w_flush0;
    logic [LEN_W-1:0]      w_len_a;
    logic                  w_flush1;

    assign i_pix.ready = !i_full;
    assign w_accept    = i_pix.valid && !i_full;
    assign w_pix       = i_pix.pixel_value[PIXEL_BITS-1:0];
    assign w_thr       = (r_thr > THR_CAP) ? LEN_W'(THR_CAP) : LEN_W'(r_thr);

    always_comb begin
        w_flush0 = (r_cur_len != '0) && (w_pix != r_cur_val);
        w_len_a  = (w_flush0 || (r_cur_len == '0)) ? LEN_W'(1) : r_cur_len + LEN_W'(1);
        w_flush1 = (w_len_a == LEN_W'(MAX_RUN_LENGTH)) || i_pix.row_end;

        o_cmd.v0   = w_flush0;
        o_cmd.tok0 = r_cur_len > w_thr;
        o_cmd.val0 = r_cur_val;
        o_cmd.len0 = r_cur_len;
        o_cmd.v1   = w_flush1;
        o_cmd.tok1 = w_len_a > w_thr;
        o_cmd.val1 = w_pix;
        o_cmd.len1 = w_len_a;
        o_cmd.mark = i_pix.row_end;

        o_push    = w_accept && (w_flush0 || w_flush1);
        n_cur_val = w_accept ? w_pix : r_cur_val;
        n_cur_len = r_cur_len;
        if (w_accept) begin
            n_cur_len = w_flush1 ? '0 : w_len_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_val <= '0;
            r_cur_len <= '0;
            r_thr     <= THR_RESET;
        end else begin
            r_cur_val <= n_cur_val;
            r_cur_len <= n_cur_len;
            if (i_cfg_we) begin
                r_thr <= i_cfg_data;
            end
        end
    end

endmodule

[sv/prle_fifo.sv]
// small command queue between front and back
module prle_fifo #(
    parameter int  DEPTH = prle_pkg::FIFO_DEPTH_DEF,
    parameter type t_cmd = logic
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_cmd o_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push, w_pop;

    assign o_full  = r_count == CNT_W'(DEPTH);
    assign o_empty = r_count == '0;
    assign o_data  = r_mem[r_rptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
            end
            r_count <= r_count + CNT_W'(w_push) - CNT_W'(w_pop);
        end
    end

endmodule

[sv/prle_back.sv]
// back end: expands commands into token beats behind an output register
module prle_back #(
    parameter int  PIXEL_BITS = prle_pkg::PIXEL_BITS_DEF,
    parameter int  LEN_W      = 13,
    parameter type t_cmd      = logic
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_empty,
    input  t_cmd       i_cmd,
    output logic       o_pop,
    prle_tok_if.source o_tok
);
    import prle_pkg::*;

    localparam logic [1:0] PH_RUN0 = 2'd0;
    localparam logic [1:0] PH_RUN1 = 2'd1;
    localparam logic [1:0] PH_MARK = 2'd2;

    logic [1:0]      r_phase, n_phase;
    logic [THR_W-1:0] r_done, n_done;
    logic            r_valid;
    t_kind           r_kind;
    t_value          r_value;
    t_count          r_count;
    logic            r_last;

    logic                  w_load, w_fire;
    logic [1:0]            w_seg;
    logic                  w_tok;
    logic [PIXEL_BITS-1:0] w_val;
    logic [LEN_W-1:0]      w_len;
    logic                  w_seg_done, w_later, w_last;
    t_kind                 w_kind;

    assign w_load = !r_valid || o_tok.ready;
    assign w_fire = w_load && !i_empty;

    always_comb begin
        if (r_phase == PH_RUN0 && i_cmd.v0) begin
            w_seg = PH_RUN0;
        end else if (r_phase != PH_MARK && i_cmd.v1) begin
            w_seg = PH_RUN1;
        end else begin
            w_seg = PH_MARK;
        end

        w_tok   = 1'b0;
        w_val   = i_cmd.val0;
        w_len   = i_cmd.len0;
        w_later = 1'b0;
        unique case (w_seg)
            PH_RUN0: begin
                w_tok   = i_cmd.tok0;
                w_later = i_cmd.v1 || i_cmd.mark;
            end
            PH_RUN1: begin
                w_tok   = i_cmd.tok1;
                w_val   = i_cmd.val1;
                w_len   = i_cmd.len1;
                w_later = i_cmd.mark;
            end
            default: begin
                w_later = 1'b0;
            end
        endcase

        w_seg_done = (w_seg == PH_MARK) || w_tok
                     || (LEN_W'(r_done) + LEN_W'(1) == w_len);
        w_last     = w_seg_done && !w_later;
        o_pop      = w_fire && w_last;

        if (w_seg == PH_MARK) begin
            w_kind = KIND_ROW_END;
        end else if (w_tok) begin
            w_kind = KIND_RUN;
        end else begin
            w_kind = KIND_LITERAL;
        end

        n_phase = r_phase;
        n_done  = r_done;
        if (w_fire) begin
            if (w_last) begin
                n_phase = PH_RUN0;
                n_done  = '0;
            end else if (w_seg_done) begin
                n_phase = (w_seg == PH_RUN0) ? PH_RUN1 : PH_MARK;
                n_done  = '0;
            end else begin
                n_done = r_done + THR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_RUN0;
            r_done  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_done  <= n_done;
            if (w_load) begin
                r_valid <= !i_empty;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_kind  <= w_kind;
            r_value <= (w_seg == PH_MARK) ? '0 : VALUE_W'(w_val);
            r_count <= (w_seg == PH_MARK) ? '0 : (w_tok ? COUNT_W'(w_len) : COUNT_W'(1));
            r_last  <= w_last;
        end
    end

    assign o_tok.valid         = r_valid;
    assign o_tok.token_kind    = r_kind;
    assign o_tok.token_value   = r_value;
    assign o_tok.run_count     = r_count;
    assign o_tok.last_of_burst = r_last;

endmodule

[sv/pixel_row_run_length_encoder.sv]
// pixel row run-length encoder top level
//
//  port      dir  beat contents                                      handshake
//  i_pix     in   pixel_value[15:0], row_end                         valid/ready
//  o_tok     out  token_kind[1:0], token_value[15:0], run_count[12:0],
//                 last_of_burst                                       valid/ready
//  i_cfg_*   in   min_run_threshold[3:0]                             write enable
//
//  a pixel is accepted every cycle while the command queue has room; the
//  front resolves it in the cycle it is taken and queues at most one command
//  the back emits one token beat per cycle from the queue head while o_tok
//  is not stalled, up to ten per command, through a single output register;
//  a pixel's first beat passes through the command queue, then that register
//  either side stalls alone; a full queue holds i_pix.ready low
//  reset is synchronous: run state, queue, output valid and threshold (3)
module pixel_row_run_length_encoder #(
    parameter int PIXEL_BITS     = prle_pkg::PIXEL_BITS_DEF,
    parameter int MAX_RUN_LENGTH = prle_pkg::MAX_RUN_LENGTH_DEF,
    parameter int FIFO_DEPTH     = prle_pkg::FIFO_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    prle_pix_if.sink       i_pix,
    prle_tok_if.source     o_tok,
    input  logic           i_cfg_we,
    input  prle_pkg::t_thr i_cfg_data
);
    import prle_pkg::*;

    localparam int LEN_W = $clog2(MAX_RUN_LENGTH + 1);

    typedef struct packed {
        logic                  v0;
        logic                  tok0;
        logic [PIXEL_BITS-1:0] val0;
        logic [LEN_W-1:0]      len0;
        logic                  v1;
        logic                  tok1;
        logic [PIXEL_BITS-1:0] val1;
        logic [LEN_W-1:0]      len1;
        logic                  mark;
    } t_cmd;

    logic w_push, w_pop, w_full, w_empty;
    t_cmd w_cmd_in, w_cmd_out;

    prle_front #(
        .PIXEL_BITS     (PIXEL_BITS),
        .MAX_RUN_LENGTH (MAX_RUN_LENGTH),
        .LEN_W          (LEN_W),
        .t_cmd          (t_cmd)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (i_pix),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_cmd      (w_cmd_in)
    );

    prle_fifo #(
        .DEPTH (FIFO_DEPTH),
        .t_cmd (t_cmd)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_cmd_in),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_data  (w_cmd_out)
    );

    prle_back #(
        .PIXEL_BITS (PIXEL_BITS),
        .LEN_W      (LEN_W),
        .t_cmd      (t_cmd)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_cmd   (w_cmd_out),
        .o_pop   (w_pop),
        .o_tok   (o_tok)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("command queue overflow");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("command queue underflow");

    a_row_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tok.valid && o_tok.token_kind == KIND_ROW_END) |-> o_tok.last_of_burst)
        else $error("row end marker not last of burst");

    a_literal_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tok.valid && o_tok.token_kind == KIND_LITERAL) |-> o_tok.run_count == COUNT_W'(1))
        else $error("literal with count other than one");

    a_kind_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tok.valid |-> o_tok.token_kind != KIND_UNUSED)
        else $error("unused token kind");

endmodule

[test/pixel_row_run_length_encoder_tb.sv]
`timescale 1ns / 100ps
// self-checking testbench for the pixel row run-length encoder: directed table, then random rows
module pixel_row_run_length_encoder_tb;
    import prle_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int RANDOM_ITEMS   = 216;
    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 10;

    typedef enum logic {OP_PIXEL, OP_THRESHOLD} t_plan_op;

    typedef struct packed {
        t_kind  kind;
        t_value value;
        t_count count;
        logic   last;
    } t_token;

    typedef struct packed {
        t_plan_op    op;
        t_value      pixel;
        logic        row_end;
        logic [12:0] reps;
        t_thr        thr;
        logic        typed;
        t_token      first_token;
    } t_plan_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic cfg_we;
    t_thr cfg_data;

    prle_pix_if pix_bus ();
    prle_tok_if tok_bus ();

    pixel_row_run_length_encoder i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (pix_bus),
        .o_tok      (tok_bus),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    t_thr      threshold;
    t_value    run_value;
    int        run_len;
    t_token    burst [0:9];
    t_token    expected_tokens [$];
    t_plan_row plan [$];
    int        idle_pct = 0;
    int        stall_pct = 0;
    int        mismatches = 0;
    int        quiet_cycles = 0;

    function automatic int add_token(input int n, input t_kind kind, input t_value value,
                                     input t_count count);
        burst[n].kind  = kind;
        burst[n].value = value;
        burst[n].count = count;
        burst[n].last  = 1'b0;
        return n + 1;
    endfunction

    function automatic int close_run(input int n);
        int   k;
        int   m;
        t_thr eff;
        eff = (threshold > THR_CAP) ? THR_CAP : threshold;
        m = n;
        if (run_len != 0) begin
            if (run_len > eff) begin
                m = add_token(m, KIND_RUN, run_value, t_count'(run_len));
            end else begin
                for (k = 0; k < run_len; k++)
                    m = add_token(m, KIND_LITERAL, run_value, 13'd1);
            end
            run_len = 0;
        end
        return m;
    endfunction

    function automatic int encode_pixel(input t_value pv, input logic re);
        int n;
        n = 0;
        if (run_len != 0 && pv != run_value)
            n = close_run(n);
        if (run_len == 0) begin
            run_value = pv;
            run_len   = 1;
        end else begin
            run_len++;
        end
        if (run_len >= MAX_RUN_LENGTH_DEF)
            n = close_run(n);
        if (re) begin
            n = close_run(n);
            n = add_token(n, KIND_ROW_END, '0, '0);
        end
        return n;
    endfunction

    function automatic t_plan_row mk_row(input t_plan_op op, input t_value pixel,
                                         input logic row_end, input int reps, input t_thr thr,
                                         input logic typed, input t_kind kind,
                                         input t_value value, input t_count count);
        t_plan_row r;
        r.op                = op;
        r.pixel             = pixel;
        r.row_end           = row_end;
        r.reps              = 13'(reps);
        r.thr               = thr;
        r.typed             = typed;
        r.first_token.kind  = kind;
        r.first_token.value = value;
        r.first_token.count = count;
        r.first_token.last  = 1'b0;
        return r;
    endfunction

    function automatic void log_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s", $time, msg);
    endfunction

    task automatic push_pixel(input t_value pv, input logic re, input logic typed,
                              input t_token first);
        int     n;
        int     k;
        t_token marker;
        while ($urandom_range(99) < idle_pct) begin
            pix_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_bus.valid       <= 1'b1;
        pix_bus.pixel_value <= pv;
        pix_bus.row_end     <= re;
        @(posedge i_clk);
        while (!pix_bus.ready)
            @(posedge i_clk);
        n = encode_pixel(pv, re);
        if (typed) begin
            marker.kind  = KIND_ROW_END;
            marker.value = '0;
            marker.count = '0;
            marker.last  = 1'b1;
            first.last   = 1'b0;
            expected_tokens.push_back(first);
            expected_tokens.push_back(marker);
        end else begin
            for (k = 0; k < n; k++) begin
                burst[k].last = (k == n - 1);
                expected_tokens.push_back(burst[k]);
            end
        end
    endtask

    task automatic set_threshold(input t_thr value);
        pix_bus.valid <= 1'b0;
        while (expected_tokens.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        threshold = value;
    endtask

    // output sink, token check and watchdog
    always @(posedge i_clk) begin
        t_token got;
        t_token want;
        tok_bus.ready <= ($urandom_range(99) >= stall_pct);
        if (i_rst_n && tok_bus.valid && tok_bus.ready) begin
            got.kind  = tok_bus.token_kind;
            got.value = tok_bus.token_value;
            got.count = tok_bus.run_count;
            got.last  = tok_bus.last_of_burst;
            if (expected_tokens.size() == 0) begin
                log_mismatch($sformatf("unexpected beat: kind %0d value %h count %0d last %b",
                                       got.kind, got.value, got.count, got.last));
            end else begin
                want = expected_tokens.pop_front();
                if (got.kind != want.kind || got.value != want.value ||
                    got.count != want.count || got.last != want.last)
                    log_mismatch($sformatf({"beat mismatch: expected kind %0d value %h count %0d",
                                            " last %b, got kind %0d value %h count %0d last %b"},
                                           want.kind, want.value, want.count, want.last,
                                           got.kind, got.value, got.count, got.last));
            end
        end
        if ((pix_bus.valid && pix_bus.ready) || (tok_bus.valid && tok_bus.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        int     ph;
        int     sent;
        int     row_left;
        int     run_n;
        int     k;
        int     r;
        t_value v;
        t_value palette [4];
        t_thr   phase_thr [4];
        int     phase_idle [4];
        int     phase_stall [4];
        t_token none;

        palette     = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF};
        phase_thr   = '{4'd1, 4'd5, 4'd8, t_thr'($urandom_range(15))};
        phase_idle  = '{0, 59, 0, 26};
        phase_stall = '{0, 0, 59, 26};
        none        = '0;

        threshold = THR_RESET;
        run_value = '0;
        run_len   = 0;

        i_rst_n             <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_data            <= '0;
        pix_bus.valid       <= 1'b0;
        pix_bus.pixel_value <= '0;
        pix_bus.row_end     <= 1'b0;

        // reset threshold, pixel zero right after reset
        plan.push_back(mk_row(OP_PIXEL, 16'h0000, 1'b1, 1, '0, 1'b1, KIND_LITERAL, 16'h0000, 13'd1));
        plan.push_back(mk_row(OP_PIXEL, 16'hFFFF, 1'b0, 3, '0, 1'b0, KIND_LITERAL, '0, '0));
        plan.push_back(mk_row(OP_PIXEL, 16'hFFFF, 1'b1, 1, '0, 1'b1, KIND_RUN, 16'hFFFF, 13'd4));
        plan.push_back(mk_row(OP_PIXEL, 16'h1234, 1'b0, 3, '0, 1'b0, KIND_LITERAL, '0, '0));
        plan.push_back(mk_row(OP_PIXEL, 16'h5678, 1'b1, 1, '0, 1'b0, KIND_LITERAL, '0, '0));
        plan.push_back(mk_row(OP_PIXEL, 16'hAAAA, 1'b0, 1, '0, 1'b0, KIND_LITERAL, '0, '0));
        plan.push_back(mk_row(OP_PIXEL, 16'h5555, 1'b0, 2, '0, 1'b0, KIND_LITERAL, '0, '0));
        plan.push_back(mk_row(OP_PIXEL, 16'h5555, 1'b1, 1, '0, 1'b0, KIND_LITERAL, '0, '0));
        // threshold zero: single pixels become run tokens
        plan.push_back(mk_row(OP_THRESHOLD, '0, 1'b0, 0, 4'd0, 1'b0, KIND_LITERAL, '0, '0));
        plan.push_back(mk_row(OP_PIXEL, 16'h00FF, 1'b1, 1, '0, 1'b1, KIND_RUN, 16'h00FF, 13'd1));
        plan.push_back(mk_row(OP_PIXEL, 16'h0001, 1'b0, 2, '0, 1'b0, KIND_LITERAL, '0, '0));
        plan.push_back(mk_row(OP_PIXEL, 16'h0002, 1'b1, 1, '0, 1'b0, KIND_LITERAL, '0, '0));
        // threshold above range acts as the cap, ten beats from one pixel
        plan.push_back(mk_row(OP_THRESHOLD, '0, 1'b0, 0, 4'd15, 1'b0, KIND_LITERAL, '0, '0));
        plan.push_back(mk_row(OP_PIXEL, 16'h0007, 1'b0, 8, '0, 1'b0, KIND_LITERAL, '0, '0));
        plan.push_back(mk_row(OP_PIXEL, 16'h0009, 1'b1, 1, '0, 1'b0, KIND_LITERAL, '0, '0));
        plan.push_back(mk_row(OP_THRESHOLD, '0, 1'b0, 0, 4'd8, 1'b0, KIND_LITERAL, '0, '0));
        plan.push_back(mk_row(OP_PIXEL, 16'h0007, 1'b0, 9, '0, 1'b0, KIND_LITERAL, '0, '0));
        plan.push_back(mk_row(OP_PIXEL, 16'h0007, 1'b1, 1, '0, 1'b1, KIND_RUN, 16'h0007, 13'd10));
        plan.push_back(mk_row(OP_THRESHOLD, '0, 1'b0, 0, 4'd1, 1'b0, KIND_LITERAL, '0, '0));
        plan.push_back(mk_row(OP_PIXEL, 16'h8000, 1'b0, 1, '0, 1'b0, KIND_LITERAL, '0, '0));
        plan.push_back(mk_row(OP_PIXEL, 16'h8000, 1'b1, 1, '0, 1'b1, KIND_RUN, 16'h8000, 13'd2));
        plan.push_back(mk_row(OP_PIXEL, 16'h0001, 1'b1, 1, '0, 1'b1, KIND_LITERAL, 16'h0001, 13'd1));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (r = 0; r < plan.size(); r++) begin
            if (plan[r].op == OP_THRESHOLD) begin
                set_threshold(plan[r].thr);
            end else begin
                for (k = 0; k < plan[r].reps; k++)
                    push_pixel(plan[r].pixel, plan[r].row_end, plan[r].typed, plan[r].first_token);
            end
        end

        // random rows built from runs, with some loose pixels mixed in
        for (ph = 0; ph < 4; ph++) begin
            set_threshold(phase_thr[ph]);
            idle_pct  = phase_idle[ph];
            stall_pct = phase_stall[ph];
            sent = 0;
            while (sent < RANDOM_ITEMS / 4) begin
                if ($urandom_range(9) == 0) begin
                    push_pixel(t_value'($urandom), 1'($urandom_range(1)), 1'b0, none);
                    sent++;
                end else begin
                    row_left = $urandom_range(1, 24);
                    while (row_left > 0) begin
                        run_n = $urandom_range(1, 10);
                        if (run_n > row_left)
                            run_n = row_left;
                        v = $urandom_range(1) ? palette[$urandom_range(3)] : t_value'($urandom);
                        for (k = 0; k < run_n; k++) begin
                            row_left--;
                            push_pixel(v, row_left == 0, 1'b0, none);
                            sent++;
                        end
                    end
                end
            end
        end

        pix_bus.valid <= 1'b0;
        while (expected_tokens.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[files.f]
sv/prle_pkg.sv
sv/prle_if.sv
sv/prle_front.sv
sv/prle_fifo.sv
sv/prle_back.sv
sv/pixel_row_run_length_encoder.sv
test/pixel_row_run_length_encoder_tb.sv
